/* hw/rtl/tdm_pkg.sv */
// shared types, codes and the speed conversion for the telemetry decimator
`default_nettype none
package tdm_pkg;

    localparam logic [15:0] PERIOD_RESET = 16'd1000;
    localparam int          TIME_W       = 40;
    localparam int          KMH_W        = 20;

    // floor(p / 5) as (p * ceil(2^26 / 5)) >> 26, exact for p below 2^26
    localparam logic [23:0] DIV5_RECIP = 24'd13421773;
    localparam int          DIV5_SHIFT = 26;

    typedef enum logic [1:0] {
        ACT_ADD       = 2'd0,
        ACT_NEW_VIDEO = 2'd1,
        ACT_QUERY     = 2'd2
    } action_t;

    typedef enum logic [2:0] {
        SEL_LAT    = 3'd0,
        SEL_LON    = 3'd1,
        SEL_ALT    = 3'd2,
        SEL_GROUND = 3'd3,
        SEL_SPACE  = 3'd4
    } field_sel_t;

    typedef struct packed {
        logic signed [30:0] lat;
        logic signed [31:0] lon;
        logic signed [24:0] alt;
        logic [KMH_W-1:0]   ground;
        logic [KMH_W-1:0]   space;
    } sample_t;

    typedef struct packed {
        logic       upd;
        logic       first;
        logic [2:0] sel;
    } trk_ctrl_t;

    // mm/s to km/h x1000: floor(v * 18 / 5)
    function automatic logic [KMH_W-1:0] mms_to_kmh(input logic [17:0] v);
        logic [22:0] p;
        logic [46:0] prod;
        begin
            p    = {1'b0, v, 4'b0000} + {4'b0000, v, 1'b0};
            prod = {24'd0, p} * {23'd0, DIV5_RECIP};
            return prod[DIV5_SHIFT +: KMH_W];
        end
    endfunction

endpackage
`default_nettype wire

/* hw/rtl/tdm_extremes.sv */
// running minimum and maximum of the five sample quantities
`default_nettype none
module tdm_extremes (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire tdm_pkg::trk_ctrl_t  ctrl,
    input  wire tdm_pkg::sample_t    smp,
    output logic signed [31:0]       ext_min,
    output logic signed [31:0]       ext_max
);
    import tdm_pkg::*;

    logic signed [30:0] lat_min_reg, lat_max_reg, lat_min_next, lat_max_next;
    logic signed [31:0] lon_min_reg, lon_max_reg, lon_min_next, lon_max_next;
    logic signed [24:0] alt_min_reg, alt_max_reg, alt_min_next, alt_max_next;
    logic [KMH_W-1:0]   gnd_min_reg, gnd_max_reg, gnd_min_next, gnd_max_next;
    logic [KMH_W-1:0]   spc_min_reg, spc_max_reg, spc_min_next, spc_max_next;

    always_comb begin
        lat_min_next = lat_min_reg;
        lat_max_next = lat_max_reg;
        lon_min_next = lon_min_reg;
        lon_max_next = lon_max_reg;
        alt_min_next = alt_min_reg;
        alt_max_next = alt_max_reg;
        gnd_min_next = gnd_min_reg;
        gnd_max_next = gnd_max_reg;
        spc_min_next = spc_min_reg;
        spc_max_next = spc_max_reg;
        if (ctrl.upd) begin
            if (ctrl.first || smp.lat < lat_min_reg) lat_min_next = smp.lat;
            if (ctrl.first || smp.lat > lat_max_reg) lat_max_next = smp.lat;
            if (ctrl.first || smp.lon < lon_min_reg) lon_min_next = smp.lon;
            if (ctrl.first || smp.lon > lon_max_reg) lon_max_next = smp.lon;
            if (ctrl.first || smp.alt < alt_min_reg) alt_min_next = smp.alt;
            if (ctrl.first || smp.alt > alt_max_reg) alt_max_next = smp.alt;
            if (ctrl.first || smp.ground < gnd_min_reg) gnd_min_next = smp.ground;
            if (ctrl.first || smp.ground > gnd_max_reg) gnd_max_next = smp.ground;
            if (ctrl.first || smp.space < spc_min_reg) spc_min_next = smp.space;
            if (ctrl.first || smp.space > spc_max_reg) spc_max_next = smp.space;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lat_min_reg <= '0;
            lat_max_reg <= '0;
            lon_min_reg <= '0;
            lon_max_reg <= '0;
            alt_min_reg <= '0;
            alt_max_reg <= '0;
            gnd_min_reg <= '0;
            gnd_max_reg <= '0;
            spc_min_reg <= '0;
            spc_max_reg <= '0;
        end else begin
            lat_min_reg <= lat_min_next;
            lat_max_reg <= lat_max_next;
            lon_min_reg <= lon_min_next;
            lon_max_reg <= lon_max_next;
            alt_min_reg <= alt_min_next;
            alt_max_reg <= alt_max_next;
            gnd_min_reg <= gnd_min_next;
            gnd_max_reg <= gnd_max_next;
            spc_min_reg <= spc_min_next;
            spc_max_reg <= spc_max_next;
        end
    end

    // report the values as they stand after this item
    always_comb begin
        case (ctrl.sel)
            SEL_LAT: begin
                ext_min = {lat_min_next[30], lat_min_next};
                ext_max = {lat_max_next[30], lat_max_next};
            end
            SEL_LON: begin
                ext_min = lon_min_next;
                ext_max = lon_max_next;
            end
            SEL_ALT: begin
                ext_min = {{7{alt_min_next[24]}}, alt_min_next};
                ext_max = {{7{alt_max_next[24]}}, alt_max_next};
            end
            SEL_GROUND: begin
                ext_min = {12'd0, gnd_min_next};
                ext_max = {12'd0, gnd_max_next};
            end
            SEL_SPACE: begin
                ext_min = {12'd0, spc_min_next};
                ext_max = {12'd0, spc_max_next};
            end
            default: begin
                ext_min = '0;
                ext_max = '0;
            end
        endcase
    end

endmodule
`default_nettype wire

/* hw/rtl/telemetry_decimator_minmax.sv */
// top level of the telemetry decimator with running min/max tracking
`default_nettype none
// usage
//   s_ channel: one telemetry beat per item; s_tuser carries the action
//   (add sample, new video segment, query). m_ channel: one result beat per
//   item, in order. cfg_we/cfg_wdata load the sample period in ms; write it
//   only while no item is in flight.
// pipeline and throughput
//   a result beat passes the input register (speeds already converted on
//   the way in), then the result register, which takes the acceptance
//   decision and min/max update.
//   while m_tready stays high, one beat per cycle is sustained; the decision
//   logic and the timeline state are all updated in the single second stage.
// reset
//   aresetn low clears the timeline offset, due time, counters, extremes and
//   both valid flags, and sets the period to 1000 ms.
// backpressure
//   while m_tready is low the result register holds; the input register
//   still fills once, after that s_tready drops until the result is taken.
module telemetry_decimator_minmax (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    // configuration
    input  wire logic         cfg_we,
    input  wire logic [15:0]  cfg_wdata,
    // input stream
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // timestamp, latitude, longitude, altitude, ground_speed, space_speed,
    // field_select, zero pad
    input  wire logic [159:0] s_tdata,
    // action
    input  wire logic [1:0]   s_tuser,
    // result stream
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // drift, out_latitude, out_longitude, out_altitude, out_ground_kmh,
    // out_space_kmh, accepted_count, extreme_min, extreme_max
    output logic [263:0]      m_tdata,
    // accepted, extremes_valid
    output logic [1:0]        m_tuser
);
    import tdm_pkg::*;

    // configuration
    logic [15:0] period_reg;

    // input stage
    logic                in_valid_reg;
    logic [1:0]          in_act_reg;
    logic [31:0]         in_ts_reg;
    logic [2:0]          in_sel_reg;
    sample_t             in_smp_reg;
    logic                in_ready;
    logic                in_take;
    sample_t             s_smp;

    // result stage
    logic                out_valid_reg;
    logic                out_ready;
    logic                out_take;
    logic                out_acc_reg;
    logic                out_ev_reg;
    logic [TIME_W-1:0]   out_drift_reg;
    sample_t             out_smp_reg;
    logic [31:0]         out_count_reg;
    logic signed [31:0]  out_min_reg;
    logic signed [31:0]  out_max_reg;

    // timeline state
    logic                have_reg,   have_next;
    logic [TIME_W-1:0]   seg_off_reg, seg_off_next;
    logic [TIME_W-1:0]   due_reg,    due_next;
    logic [31:0]         last_ts_reg, last_ts_next;
    logic [31:0]         total_reg,  total_next;

    // decision
    logic                is_add;
    logic                hit;
    logic [TIME_W-1:0]   t_off;
    logic [TIME_W:0]     late_lim;
    logic [TIME_W:0]     late_diff;
    logic [TIME_W-1:0]   drift;
    trk_ctrl_t           trk_ctrl;
    logic signed [31:0]  ext_min;
    logic signed [31:0]  ext_max;

    // handshakes: result register frees when taken, input stage flows into it
    assign out_ready = !out_valid_reg || m_tready;
    assign in_ready  = !in_valid_reg || out_ready;
    assign s_tready  = in_ready;
    assign in_take   = s_tvalid && in_ready;
    assign out_take  = in_valid_reg && out_ready;

    // unpack the input beat, speeds converted on the way in
    always_comb begin
        s_smp.lat    = s_tdata[62:32];
        s_smp.lon    = s_tdata[94:63];
        s_smp.alt    = s_tdata[119:95];
        s_smp.ground = mms_to_kmh(s_tdata[137:120]);
        s_smp.space  = mms_to_kmh(s_tdata[155:138]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_reg <= PERIOD_RESET;
        end else if (cfg_we) begin
            period_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (in_ready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_take) begin
            in_act_reg <= s_tuser;
            in_ts_reg  <= s_tdata[31:0];
            in_sel_reg <= s_tdata[158:156];
            in_smp_reg <= s_smp;
        end
    end

    // acceptance on the offset timeline
    always_comb begin
        is_add    = (in_act_reg == ACT_ADD);
        t_off     = {8'd0, in_ts_reg} + seg_off_reg;
        hit       = is_add && (!have_reg || (t_off >= due_reg));
        // due time plus half a period, kept one bit wider so it never wraps
        late_lim  = {1'b0, due_reg} + {{(TIME_W-14){1'b0}}, period_reg[15:1]};
        late_diff = {1'b0, t_off} - late_lim;
        if (hit && have_reg && ({1'b0, t_off} > late_lim)) begin
            drift = late_diff[TIME_W-1:0];
        end else begin
            drift = '0;
        end
    end

    always_comb begin
        have_next    = have_reg;
        seg_off_next = seg_off_reg;
        due_next     = due_reg;
        last_ts_next = last_ts_reg;
        total_next   = total_reg;
        if (out_take) begin
            case (in_act_reg)
                ACT_ADD: begin
                    have_next    = 1'b1;
                    last_ts_next = in_ts_reg;
                    if (hit) begin
                        due_next   = due_reg + {{(TIME_W-16){1'b0}}, period_reg};
                        total_next = total_reg + 32'd1;
                    end
                end
                ACT_NEW_VIDEO: begin
                    seg_off_next = seg_off_reg + {8'd0, last_ts_reg};
                end
                default: begin
                    // query and the unused code change nothing
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            have_reg    <= 1'b0;
            seg_off_reg <= '0;
            due_reg     <= '0;
            last_ts_reg <= '0;
            total_reg   <= '0;
        end else begin
            have_reg    <= have_next;
            seg_off_reg <= seg_off_next;
            due_reg     <= due_next;
            last_ts_reg <= last_ts_next;
            total_reg   <= total_next;
        end
    end

    assign trk_ctrl.upd   = out_take && is_add;
    assign trk_ctrl.first = !have_reg;
    assign trk_ctrl.sel   = in_sel_reg;

    tdm_extremes u_extremes (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (trk_ctrl),
        .smp     (in_smp_reg),
        .ext_min (ext_min),
        .ext_max (ext_max)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_ready) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_take) begin
            out_acc_reg   <= hit;
            out_ev_reg    <= have_next;
            out_drift_reg <= drift;
            out_smp_reg   <= hit ? in_smp_reg : '0;
            out_count_reg <= total_next;
            out_min_reg   <= ext_min;
            out_max_reg   <= ext_max;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = {out_ev_reg, out_acc_reg};
    assign m_tdata  = {out_max_reg, out_min_reg, out_count_reg,
                       out_smp_reg.space, out_smp_reg.ground, out_smp_reg.alt,
                       out_smp_reg.lon, out_smp_reg.lat, out_drift_reg};

endmodule
`default_nettype wire
